[hw/rtl/crlf_line_framer_unit_macros.svh]
// Assertion macros for the line framer port checker.
`ifndef CRLF_LINE_FRAMER_UNIT_MACROS_SVH
`define CRLF_LINE_FRAMER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CLF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("line framer check failed");

// Next-cycle implication, disabled during reset.
`define CLF_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("line framer check failed");

`endif

[hw/rtl/clf_pkg.sv]
// Types and constants shared by the CR/LF line framer modules.
`default_nettype none
package clf_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LINE_LEN_W = 6;

  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_FETCH,
    ST_SHOW
  } clf_state_t;

  typedef struct packed {
    logic store;
    logic drop;
    logic arm;
    logic start;
    logic fetch;
    logic advance;
  } clf_cmd_t;

  typedef struct packed {
    logic is_cr;
    logic is_lf;
    logic fill_zero;
    logic fill_full;
    logic armed;
    logic at_last;
  } clf_status_t;

endpackage
`default_nettype wire

[hw/rtl/clf_rx_if.sv]
// Request channel carrying one received byte.
`default_nettype none
interface clf_rx_if;
  logic                       valid;
  logic                       ready;
  logic [clf_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

[hw/rtl/clf_line_if.sv]
// Request channel carrying one character of a completed line.
`default_nettype none
interface clf_line_if;
  logic                           valid;
  logic                           ready;
  logic [clf_pkg::BYTE_W-1:0]     line_byte;
  logic                           line_last;
  logic [clf_pkg::LINE_LEN_W-1:0] line_length;

  modport source (output valid, output line_byte, output line_last, output line_length,
                  input ready);
  modport sink (input valid, input line_byte, input line_last, input line_length,
                output ready);
endinterface
`default_nettype wire

[hw/rtl/clf_ctrl.sv]
// Controller state machine for the CR/LF line framer.
`default_nettype none
module clf_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire clf_pkg::clf_status_t status,
  output clf_pkg::clf_cmd_t         cmd
);

  clf_pkg::clf_state_t state;
  clf_pkg::clf_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= clf_pkg::ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      clf_pkg::ST_COLLECT: begin
        in_ready = 1'b1;
        if (in_valid) begin
          priority if (!status.is_cr && !status.is_lf) begin
            if (status.fill_full) begin
              cmd.drop = 1'b1;
            end else begin
              cmd.store = 1'b1;
            end
          end else if (status.fill_zero) begin
            cmd = '0;
          end else if (!status.armed) begin
            if (status.is_cr) begin
              cmd.arm = 1'b1;
            end else begin
              cmd.drop = 1'b1;
            end
          end else if (status.is_lf) begin
            cmd.start  = 1'b1;
            state_next = clf_pkg::ST_FETCH;
          end else begin
            cmd.drop = 1'b1;
          end
        end
      end
      clf_pkg::ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = clf_pkg::ST_SHOW;
      end
      clf_pkg::ST_SHOW: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (status.at_last) begin
            state_next = clf_pkg::ST_COLLECT;
          end else begin
            cmd.advance = 1'b1;
            state_next  = clf_pkg::ST_FETCH;
          end
        end
      end
      default: begin
        state_next = clf_pkg::ST_COLLECT;
      end
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/clf_dp.sv]
// Datapath of the CR/LF line framer: line store, fill count and replay counter.
`default_nettype none
module clf_dp #(
  parameter int unsigned LINE_BYTES = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire clf_pkg::clf_cmd_t              cmd,
  input  wire logic [clf_pkg::BYTE_W-1:0]     rx_byte,
  output clf_pkg::clf_status_t                status,
  output logic [clf_pkg::BYTE_W-1:0]          line_byte,
  output logic                                line_last,
  output logic [clf_pkg::LINE_LEN_W-1:0]      line_length
);

  localparam int unsigned AW = $clog2(LINE_BYTES);

  logic [clf_pkg::BYTE_W-1:0] mem [LINE_BYTES];
  logic [clf_pkg::BYTE_W-1:0] rd_data;
  logic [AW-1:0]              fill;
  logic                       armed;
  logic [AW-1:0]              idx;
  logic [AW-1:0]              len;

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[fill] <= rx_byte;
    end
    if (cmd.fetch) begin
      rd_data <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill  <= '0;
      armed <= 1'b0;
    end else begin
      priority if (cmd.store) begin
        fill <= fill + AW'(1);
      end else if (cmd.drop || cmd.start) begin
        fill  <= '0;
        armed <= 1'b0;
      end else if (cmd.arm) begin
        armed <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      idx <= '0;
      len <= fill;
    end else if (cmd.advance) begin
      idx <= idx + AW'(1);
    end
  end

  always_comb begin
    status.is_cr     = (rx_byte == clf_pkg::CHAR_CR);
    status.is_lf     = (rx_byte == clf_pkg::CHAR_LF);
    status.fill_zero = (fill == '0);
    status.fill_full = (fill == AW'(LINE_BYTES - 1));
    status.armed     = armed;
    status.at_last   = (idx == len - AW'(1));
  end

  assign line_byte   = rd_data;
  assign line_last   = status.at_last;
  assign line_length = clf_pkg::LINE_LEN_W'(len);

endmodule
`default_nettype wire

[hw/rtl/crlf_line_framer_unit.sv]
// Top level of the CR/LF line framer.
// Takes one received byte per request and collects it into a line store of
// LINE_BYTES entries; a line of up to LINE_BYTES-1 characters ended by CR
// then LF is replayed as one request per character, with line_last on the
// final one and the line length on each. An ordinary byte is accepted
// whenever the block is collecting. After the closing LF the block takes no
// input while it replays the line: each character is a read of the line
// store, then the output request, and an output stall holds the replay.
// Overlong lines, an LF without a CR before it, and CR CR are dropped
// without output. No clearing pass follows reset.
`default_nettype none
module crlf_line_framer_unit #(
  parameter int unsigned LINE_BYTES = 64
) (
  input wire logic  clk,
  input wire logic  rst,
  clf_rx_if.sink    rx,
  clf_line_if.source lines
);

  clf_pkg::clf_cmd_t    cmd;
  clf_pkg::clf_status_t status;

  logic                           in_valid;
  logic                           in_ready;
  logic                           out_valid;
  logic                           out_ready;
  logic [clf_pkg::BYTE_W-1:0]     out_byte;
  logic                           out_last;
  logic [clf_pkg::LINE_LEN_W-1:0] out_length;

  assign in_valid          = rx.valid;
  assign rx.ready          = in_ready;
  assign out_ready         = lines.ready;
  assign lines.valid       = out_valid;
  assign lines.line_byte   = out_byte;
  assign lines.line_last   = out_last;
  assign lines.line_length = out_length;

  clf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  clf_dp #(
    .LINE_BYTES (LINE_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .rx_byte     (rx.rx_byte),
    .status      (status),
    .line_byte   (out_byte),
    .line_last   (out_last),
    .line_length (out_length)
  );

endmodule
`default_nettype wire

[hw/rtl/clf_checker.sv]
// Port-level checks for the CR/LF line framer, bound to the top level.
`default_nettype none
`include "crlf_line_framer_unit_macros.svh"
module clf_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [clf_pkg::BYTE_W-1:0]     out_byte,
  input wire logic                           out_last,
  input wire logic [clf_pkg::LINE_LEN_W-1:0] out_length
);

  `CLF_ASSERT_IMP(a_no_input_during_replay, clk, rst, out_valid, !in_ready)
  `CLF_ASSERT_IMP(a_length_nonzero, clk, rst, out_valid, out_length != '0)
  `CLF_ASSERT_NXT(a_stall_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_last) && $stable(out_length))
  `CLF_ASSERT_NXT(a_reopen_after_last, clk, rst, out_valid && out_ready && out_last, in_ready && !out_valid)
  `CLF_ASSERT_NXT(a_gap_between_chars, clk, rst, out_valid && out_ready && !out_last, !out_valid && !in_ready)

endmodule

bind crlf_line_framer_unit clf_checker u_clf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_byte   (out_byte),
  .out_last   (out_last),
  .out_length (out_length)
);
`default_nettype wire

[test/crlf_line_framer_checker.sv]
// Line framer checker: tracks accepted bytes, predicts completed lines and compares them.
`default_nettype none
module crlf_line_framer_checker #(
  parameter int unsigned LINE_BYTES = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  clf_rx_if         rx,
  clf_line_if       lines,
  output int        fail_count,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import clf_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0]     ch;
    logic                  last;
    logic [LINE_LEN_W-1:0] len;
  } line_char_t;

  logic [BYTE_W-1:0] shadow_store [LINE_BYTES];
  logic [6:0]        shadow_fill;
  logic              shadow_armed;
  line_char_t        expected_chars [$];
  int                fails;

  task automatic frame_byte(input logic [BYTE_W-1:0] ch);
    line_char_t c;
    if (ch != CHAR_CR && ch != CHAR_LF) begin
      shadow_store[shadow_fill] = ch;
      shadow_fill = shadow_fill + 7'd1;
      if (shadow_fill >= LINE_BYTES) begin
        shadow_fill  = '0;
        shadow_armed = 1'b0;
      end
    end else if (shadow_fill == 0) begin
    end else if (!shadow_armed) begin
      if (ch == CHAR_CR) begin
        shadow_armed = 1'b1;
      end else begin
        shadow_fill = '0;
      end
    end else if (ch != CHAR_LF) begin
      shadow_fill  = '0;
      shadow_armed = 1'b0;
    end else begin
      for (int k = 0; k < shadow_fill; k++) begin
        c.ch   = shadow_store[k];
        c.last = (k + 1 == shadow_fill);
        c.len  = shadow_fill[LINE_LEN_W-1:0];
        expected_chars.push_back(c);
      end
      shadow_fill  = '0;
      shadow_armed = 1'b0;
    end
  endtask

  initial begin
    fails = 0;
  end

  always @(posedge clk) begin
    line_char_t want;
    if (rst) begin
      shadow_fill  = '0;
      shadow_armed = 1'b0;
      expected_chars.delete();
    end else begin
      if (lines.valid && lines.ready) begin
        if (expected_chars.size() == 0) begin
          fails++;
          $display("%0t unexpected line request: expected none, actual byte %h last %b len %0d",
                   $time, lines.line_byte, lines.line_last, lines.line_length);
        end else begin
          want = expected_chars.pop_front();
          if (lines.line_byte !== want.ch) begin
            fails++;
            $display("%0t line_byte mismatch: expected %h, actual %h",
                     $time, want.ch, lines.line_byte);
          end
          if (lines.line_last !== want.last) begin
            fails++;
            $display("%0t line_last mismatch: expected %b, actual %b",
                     $time, want.last, lines.line_last);
          end
          if (lines.line_length !== want.len) begin
            fails++;
            $display("%0t line_length mismatch: expected %0d, actual %0d",
                     $time, want.len, lines.line_length);
          end
        end
      end
      if (rx.valid && rx.ready) begin
        frame_byte(rx.rx_byte);
      end
    end
    fail_count <= fails;
    pending    <= expected_chars.size();
  end
endmodule
`default_nettype wire

[test/crlf_line_framer_unit_test.sv]
// Top of the line framer test: clock, reset, byte stimulus, output back-pressure and verdict.
`default_nettype none
module crlf_line_framer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import clf_pkg::*;

  localparam int unsigned LINE_BYTES     = 64;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          PHASE_BYTES    = 4;

  logic clk = 1'b0;
  logic rst = 1'b1;

  clf_rx_if   rx_ch ();
  clf_line_if line_ch ();

  int fail_count;
  int pending;
  int src_idle;
  int snk_stall;
  int hold_seq;
  int hold_seen;
  int quiet_cycles;
  int bytes_sent;

  int phase_idle [4]  = '{0, 63, 0, 33};
  int phase_stall [4] = '{0, 0, 63, 33};

  crlf_line_framer_unit #(.LINE_BYTES(LINE_BYTES)) u_dut (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx_ch.sink),
    .lines (line_ch.source)
  );

  crlf_line_framer_checker #(.LINE_BYTES(LINE_BYTES)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx_ch),
    .lines      (line_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(0, 99) < src_idle) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input int n);
    logic [BYTE_W-1:0] b;
    for (int i = 0; i < n; i++) begin
      do b = BYTE_W'($urandom_range(0, 255)); while (b == CHAR_CR || b == CHAR_LF);
      send_byte(b);
    end
  endtask

  task automatic send_noise(input int n);
    logic [BYTE_W-1:0] b;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        b = $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
      end else begin
        b = BYTE_W'($urandom_range(0, 255));
      end
      send_byte(b);
    end
  endtask

  task automatic send_random_line();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      send_text(kind < 4 ? $urandom_range(9, 62) : $urandom_range(1, 8));
      send_byte(CHAR_CR);
      send_byte(CHAR_LF);
    end else if (kind < 70) begin
      send_text($urandom_range(1, 4));
      send_byte(CHAR_CR);
      send_text($urandom_range(1, 3));
      send_byte(CHAR_LF);
    end else if (kind < 80) begin
      send_text($urandom_range(1, 4));
      if ($urandom_range(0, 1)) begin
        send_byte(CHAR_LF);
      end else begin
        send_byte(CHAR_CR);
        send_byte(CHAR_CR);
      end
    end else begin
      send_noise($urandom_range(1, 6));
    end
  endtask

  // output back-pressure, with a long hold-off on request
  initial begin
    hold_seen = 0;
    line_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        line_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        line_ch.ready <= !rst && ($urandom_range(0, 99) >= snk_stall);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (line_ch.valid && line_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int start_count;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= '0;
    src_idle     = 0;
    snk_stall    <= 0;
    hold_seq     <= 0;
    bytes_sent   = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_byte("a");
    send_byte("b");
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
    send_byte("x");
    send_byte(CHAR_LF);
    send_byte("y");
    send_byte(CHAR_CR);
    send_byte(CHAR_CR);
    send_byte("z");
    send_byte(CHAR_CR);
    send_byte("w");
    send_byte(CHAR_LF);
    send_byte("q");
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);

    // hold the output while a full-length line waits in the store and a short one waits at the input
    hold_seq <= hold_seq + 1;
    send_text(LINE_BYTES - 1);
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
    send_text(3);
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);

    // overlong line is dropped, the tail starts a fresh one
    send_text(LINE_BYTES + 1);
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);

    for (int p = 0; p < 4; p++) begin
      src_idle  = phase_idle[p];
      snk_stall <= phase_stall[p];
      start_count = bytes_sent;
      while (bytes_sent - start_count < PHASE_BYTES) send_random_line();
    end

    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
